/* design/pwft_pkg.sv */
// Shared types, constants and the CRC-8 update function of the pulse width frame transmitter.
package pwft_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [5:0] seg_idx_t;

  typedef enum logic [2:0] {
    CFG_START_HIGH = 3'd0,
    CFG_START_LOW  = 3'd1,
    CFG_ZERO_HIGH  = 3'd2,
    CFG_ZERO_LOW   = 3'd3,
    CFG_ONE_HIGH   = 3'd4,
    CFG_ONE_LOW    = 3'd5,
    CFG_APPEND_CRC = 3'd6
  } cfg_idx_t;

  localparam byte_t CRC_INIT = 8'hFF;
  localparam byte_t CRC_POLY = 8'h1D;

  localparam byte_t RST_START_HIGH = 8'd32;
  localparam byte_t RST_START_LOW  = 8'd16;
  localparam byte_t RST_ZERO_HIGH  = 8'd14;
  localparam byte_t RST_ZERO_LOW   = 8'd8;
  localparam byte_t RST_ONE_HIGH   = 8'd5;
  localparam byte_t RST_ONE_LOW    = 8'd18;

  localparam seg_idx_t SEG_START    = 6'd0;
  localparam seg_idx_t SEG_DATA     = 6'd2;
  localparam seg_idx_t SEG_DATA_END = 6'd17;
  localparam seg_idx_t SEG_CRC_END  = 6'd33;

  function automatic byte_t crc8_update(input byte_t crc_in, input byte_t value);
    byte_t r;
    logic fb;
    r = crc_in;
    for (int k = 7; k >= 0; k--) begin
      fb = value[k] ^ r[7];
      r = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

/* design/pwft_if.sv */
// Valid/ready channel interfaces for packet bytes and line segments.
interface pwft_in_if;
  logic             valid;
  logic             ready;
  pwft_pkg::byte_t  data_byte;
  logic             first_byte;
  logic             last_byte;
  logic             no_start_pulse;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  output no_start_pulse, input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                input no_start_pulse, output ready);
endinterface

interface pwft_out_if;
  logic             valid;
  logic             ready;
  logic             line_level;
  pwft_pkg::byte_t  duration_us;
  logic             frame_end;

  modport source (output valid, output line_level, output duration_us, output frame_end,
                  input ready);
  modport sink (input valid, input line_level, input duration_us, input frame_end,
                output ready);
endinterface

/* design/pulse_width_frame_transmitter.sv */
// Pulse width frame transmitter: packet bytes in, timed line segments out, CRC-8 appended.
// A byte yields 16 segments, 18 with a start pulse, plus 16 more for an appended CRC byte.
// One segment per cycle unless stalled; a byte's first segment passes seg_r, then out_dur_r.
// The next byte is taken in the cycle its predecessor's last segment enters the output register.
// Synchronous active-low reset restores register defaults and the CRC start value.
module pulse_width_frame_transmitter (
  input  logic                 clk,
  input  logic                 rst_n,
  pwft_in_if.sink              in_ch,
  pwft_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  pwft_pkg::cfg_idx_t   cfg_index,
  input  pwft_pkg::byte_t      cfg_wdata
);
  import pwft_pkg::*;

  byte_t start_high_r, start_low_r, zero_high_r, zero_low_r, one_high_r, one_low_r;
  logic  append_crc_r;

  byte_t    crc_r;
  byte_t    data_r;
  byte_t    crcb_r;
  logic     last_r;
  logic     busy_r;
  seg_idx_t seg_r;
  seg_idx_t end_r;

  logic  out_valid_r;
  logic  out_level_r;
  byte_t out_dur_r;
  logic  out_end_r;

  logic     adv;
  logic     seg_last;
  logic     in_xfer;
  byte_t    crc_base;
  byte_t    crc_nxt;
  logic     send_crc;
  seg_idx_t k;
  byte_t    cur_byte;
  logic     cur_bit;
  byte_t    seg_dur;

  assign adv      = busy_r && (!out_valid_r || out_ch.ready);
  assign seg_last = (seg_r == end_r);
  assign in_ch.ready = !busy_r || (adv && seg_last);
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign crc_base = in_ch.first_byte ? CRC_INIT : crc_r;
  assign crc_nxt  = crc8_update(crc_base, in_ch.data_byte);
  assign send_crc = in_ch.last_byte && append_crc_r;

  assign k        = seg_r - SEG_DATA;
  assign cur_byte = k[4] ? crcb_r : data_r;
  assign cur_bit  = cur_byte[3'd7 - k[3:1]];

  always_comb begin
    if (seg_r < SEG_DATA) begin
      seg_dur = seg_r[0] ? start_low_r : start_high_r;
    end else if (cur_bit) begin
      seg_dur = k[0] ? one_low_r : one_high_r;
    end else begin
      seg_dur = k[0] ? zero_low_r : zero_high_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_high_r <= RST_START_HIGH;
      start_low_r  <= RST_START_LOW;
      zero_high_r  <= RST_ZERO_HIGH;
      zero_low_r   <= RST_ZERO_LOW;
      one_high_r   <= RST_ONE_HIGH;
      one_low_r    <= RST_ONE_LOW;
      append_crc_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_HIGH: start_high_r <= cfg_wdata;
        CFG_START_LOW:  start_low_r  <= cfg_wdata;
        CFG_ZERO_HIGH:  zero_high_r  <= cfg_wdata;
        CFG_ZERO_LOW:   zero_low_r   <= cfg_wdata;
        CFG_ONE_HIGH:   one_high_r   <= cfg_wdata;
        CFG_ONE_LOW:    one_low_r    <= cfg_wdata;
        CFG_APPEND_CRC: append_crc_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      busy_r <= 1'b0;
      seg_r  <= SEG_START;
      end_r  <= SEG_DATA_END;
    end else if (in_xfer) begin
      crc_r  <= in_ch.last_byte ? CRC_INIT : crc_nxt;
      busy_r <= 1'b1;
      seg_r  <= (in_ch.first_byte && !in_ch.no_start_pulse) ? SEG_START : SEG_DATA;
      end_r  <= send_crc ? SEG_CRC_END : SEG_DATA_END;
    end else if (adv && seg_last) begin
      busy_r <= 1'b0;
    end else if (adv) begin
      seg_r <= seg_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      data_r <= in_ch.data_byte;
      crcb_r <= ~crc_nxt;
      last_r <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_level_r <= ~seg_r[0];
      out_dur_r   <= seg_dur;
      out_end_r   <= seg_last && last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.line_level  = out_level_r;
  assign out_ch.duration_us = out_dur_r;
  assign out_ch.frame_end   = out_end_r;

endmodule
